FILE: rtl/lzsp_pkg.sv
// -----------------------------------------------------------------------------
// lzsp_pkg
// Shared widths, register map and fixed-point constants of the LIP state
// predictor.
// -----------------------------------------------------------------------------
package lzsp_pkg;

   localparam int FIELD_W    = 32;   // item field width
   localparam int VALUE_BITS = 32;   // internal state width, Q16.16
   localparam int COEF_W     = 32;   // signed Q8.24 coefficient
   localparam int UCOEF_W    = 31;   // unsigned Q7.24 coefficient
   localparam int FRAC_BITS  = 24;   // coefficient fraction bits
   localparam int NUM_AXES   = 2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // multiplier operand, product, rounded product and sum widths
   localparam int AW     = (VALUE_BITS + 1 > FIELD_W) ? VALUE_BITS + 1 : FIELD_W;
   localparam int PW     = AW + COEF_W;
   localparam int QW     = PW - FRAC_BITS;
   localparam int SUM_W  = QW + 2;
   localparam int WIDE_W = (SUM_W > FIELD_W) ? SUM_W : FIELD_W + 1;

   localparam logic [PW-1:0] ROUND_HALF =
      {{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

   localparam logic signed [WIDE_W-1:0] VALUE_MAX =
      {{(WIDE_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] VALUE_MIN = ~VALUE_MAX;
   localparam logic signed [WIDE_W-1:0] FIELD_MAX =
      {{(WIDE_W-FIELD_W+1){1'b0}}, {(FIELD_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] FIELD_MIN = ~FIELD_MAX;

   localparam logic signed [COEF_W-1:0] COSH_RESET =
      {{(COEF_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [2:0] {
      REG_COSH           = 3'd0,
      REG_SINH_OVER_ETA  = 3'd1,
      REG_ONE_MINUS_COSH = 3'd2,
      REG_ETA_SINH       = 3'd3,
      REG_INPUT_POSITION = 3'd4,
      REG_STEP_TIME      = 3'd5,
      REG_ETA_SQUARED    = 3'd6
   } csr_index_type;

   localparam logic ACTION_ADVANCE = 1'b0;
   localparam logic ACTION_RESTART = 1'b1;

endpackage

FILE: rtl/lzsp_req_if.sv
// -----------------------------------------------------------------------------
// lzsp_req_if
// Request channel: one advance or restart item per handshake.
// -----------------------------------------------------------------------------
interface lzsp_req_if;
   import lzsp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      action;
   logic signed [FIELD_W-1:0] zmp_vel_x;
   logic signed [FIELD_W-1:0] zmp_vel_y;
   logic signed [FIELD_W-1:0] start_x;
   logic signed [FIELD_W-1:0] start_y;

   modport source (output valid, action, zmp_vel_x, zmp_vel_y, start_x, start_y,
                   input ready);
   modport sink   (input valid, action, zmp_vel_x, zmp_vel_y, start_x, start_y,
                   output ready);
endinterface

FILE: rtl/lzsp_rsp_if.sv
// -----------------------------------------------------------------------------
// lzsp_rsp_if
// Response channel: new pendulum state and CoM acceleration for both axes.
// -----------------------------------------------------------------------------
interface lzsp_rsp_if;
   import lzsp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] com_x;
   logic signed [FIELD_W-1:0] com_y;
   logic signed [FIELD_W-1:0] com_speed_x;
   logic signed [FIELD_W-1:0] com_speed_y;
   logic signed [FIELD_W-1:0] zmp_x;
   logic signed [FIELD_W-1:0] zmp_y;
   logic signed [FIELD_W-1:0] com_accel_x;
   logic signed [FIELD_W-1:0] com_accel_y;

   modport source (output valid, com_x, com_y, com_speed_x, com_speed_y, zmp_x, zmp_y,
                          com_accel_x, com_accel_y,
                   input ready);
   modport sink   (input valid, com_x, com_y, com_speed_x, com_speed_y, zmp_x, zmp_y,
                         com_accel_x, com_accel_y,
                   output ready);
endinterface

FILE: rtl/lip_zmp_state_predictor.sv
// -----------------------------------------------------------------------------
// lip_zmp_state_predictor
// Two-axis linear inverted pendulum predictor: applies the discrete update
// new = A*state + B*zmp_velocity per advance item, restarts from start_x/y, and reports CoM accel.
// -----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | valid/ready          | action, zmp_vel_x/y, start_x/y
//   rsp     | out       | valid/ready          | com, speed, zmp, accel (x/y)
//   csr     | in        | APB, pready tied 1   | five Q8.24, two unsigned Q7.24 coefs
//
// Throughput is one item per cycle while rsp is not back-pressured; an item
// passes input reg -> state/stage-B reg -> result reg before it is offered.
// The rate is set by the state recurrence: the 18 parallel Q16.16 x Q8.24
// multipliers, the four-term sum and saturation close in stage A -> B.
// The acceleration multiply has its own stage (B -> C).
// Reset clears the pipeline valids and the state, and loads default coefs.
// Each stage holds while the one after it is full and not moving.
//
module lip_zmp_state_predictor (
   input  logic                           clock,
   input  logic                           reset,
   lzsp_req_if.sink                       req,
   lzsp_rsp_if.source                     rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lzsp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lzsp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lzsp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import lzsp_pkg::*;

   // ---------------------------------------------------------------------------
   // Fixed-point helpers
   // ---------------------------------------------------------------------------

   // round(a * c / 2^24), half up: floor of (a*c + 2^23) / 2^24
   function automatic logic signed [QW-1:0] qmul(input logic signed [AW-1:0]     a,
                                                 input logic signed [COEF_W-1:0] c);
      logic signed [PW-1:0] prod;
      prod = PW'(a) * PW'(c);
      prod = prod + ROUND_HALF;
      return prod[PW-1:FRAC_BITS];
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] sat_value(
      input logic signed [WIDE_W-1:0] v);
      if (v > VALUE_MAX) begin
         return {1'b0, {(VALUE_BITS-1){1'b1}}};
      end else if (v < VALUE_MIN) begin
         return {1'b1, {(VALUE_BITS-1){1'b0}}};
      end
      return v[VALUE_BITS-1:0];
   endfunction

   function automatic logic signed [FIELD_W-1:0] sat_field(
      input logic signed [VALUE_BITS-1:0] x);
      logic signed [WIDE_W-1:0] v;
      v = WIDE_W'(x);
      if (v > FIELD_MAX) begin
         return {1'b0, {(FIELD_W-1){1'b1}}};
      end else if (v < FIELD_MIN) begin
         return {1'b1, {(FIELD_W-1){1'b0}}};
      end
      return v[FIELD_W-1:0];
   endfunction

   // ---------------------------------------------------------------------------
   // Coefficient registers (APB)
   // ---------------------------------------------------------------------------
   logic signed [COEF_W-1:0] coef_cosh_ff;
   logic signed [COEF_W-1:0] coef_sinh_over_eta_ff;
   logic signed [COEF_W-1:0] coef_one_minus_cosh_ff;
   logic signed [COEF_W-1:0] coef_eta_sinh_ff;
   logic signed [COEF_W-1:0] coef_input_position_ff;
   logic [UCOEF_W-1:0]       coef_step_time_ff;
   logic [UCOEF_W-1:0]       coef_eta_squared_ff;

   logic          csr_write;
   csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_cosh_ff           <= COSH_RESET;
         coef_sinh_over_eta_ff  <= '0;
         coef_one_minus_cosh_ff <= '0;
         coef_eta_sinh_ff       <= '0;
         coef_input_position_ff <= '0;
         coef_step_time_ff      <= '0;
         coef_eta_squared_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_COSH:           coef_cosh_ff           <= csr_pwdata[COEF_W-1:0];
            REG_SINH_OVER_ETA:  coef_sinh_over_eta_ff  <= csr_pwdata[COEF_W-1:0];
            REG_ONE_MINUS_COSH: coef_one_minus_cosh_ff <= csr_pwdata[COEF_W-1:0];
            REG_ETA_SINH:       coef_eta_sinh_ff       <= csr_pwdata[COEF_W-1:0];
            REG_INPUT_POSITION: coef_input_position_ff <= csr_pwdata[COEF_W-1:0];
            REG_STEP_TIME:      coef_step_time_ff      <= csr_pwdata[UCOEF_W-1:0];
            REG_ETA_SQUARED:    coef_eta_squared_ff    <= csr_pwdata[UCOEF_W-1:0];
            default: ;  // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_COSH:           csr_prdata = coef_cosh_ff;
         REG_SINH_OVER_ETA:  csr_prdata = coef_sinh_over_eta_ff;
         REG_ONE_MINUS_COSH: csr_prdata = coef_one_minus_cosh_ff;
         REG_ETA_SINH:       csr_prdata = coef_eta_sinh_ff;
         REG_INPUT_POSITION: csr_prdata = coef_input_position_ff;
         REG_STEP_TIME:      csr_prdata = {1'b0, coef_step_time_ff};
         REG_ETA_SQUARED:    csr_prdata = {1'b0, coef_eta_squared_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // unsigned coefs zero-extended into the signed multiplier operand
   logic signed [COEF_W-1:0] coef_step_s;
   logic signed [COEF_W-1:0] coef_eta_sq_s;
   assign coef_step_s   = {{(COEF_W-UCOEF_W){1'b0}}, coef_step_time_ff};
   assign coef_eta_sq_s = {{(COEF_W-UCOEF_W){1'b0}}, coef_eta_squared_ff};

   // ---------------------------------------------------------------------------
   // Handshake: each stage moves when the next one is empty or moving
   // ---------------------------------------------------------------------------
   logic a_valid_ff, b_valid_ff, c_valid_ff;
   logic a_ready, b_ready, c_ready;
   logic a_fire;

   assign c_ready   = !c_valid_ff || rsp.ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign a_fire    = a_valid_ff && b_ready;   // item enters state update
   assign req.ready = a_ready;
   assign rsp.valid = c_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= req.valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage A: input register
   // ---------------------------------------------------------------------------
   logic                      a_action_ff;
   logic signed [FIELD_W-1:0] a_vel_ff   [NUM_AXES];
   logic signed [FIELD_W-1:0] a_start_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (a_ready && req.valid) begin
         a_action_ff   <= req.action;
         a_vel_ff[0]   <= req.zmp_vel_x;
         a_vel_ff[1]   <= req.zmp_vel_y;
         a_start_ff[0] <= req.start_x;
         a_start_ff[1] <= req.start_y;
      end
   end

   // ---------------------------------------------------------------------------
   // Pendulum state and its combinational update
   // ---------------------------------------------------------------------------
   logic signed [VALUE_BITS-1:0] pos_ff [NUM_AXES];
   logic signed [VALUE_BITS-1:0] vel_ff [NUM_AXES];
   logic signed [VALUE_BITS-1:0] piv_ff [NUM_AXES];

   logic signed [VALUE_BITS-1:0] pos_in  [NUM_AXES];
   logic signed [VALUE_BITS-1:0] vel_in  [NUM_AXES];
   logic signed [VALUE_BITS-1:0] piv_in  [NUM_AXES];
   logic signed [VALUE_BITS:0]   diff_in [NUM_AXES];

   logic signed [AW-1:0]    op_p [NUM_AXES];
   logic signed [AW-1:0]    op_v [NUM_AXES];
   logic signed [AW-1:0]    op_z [NUM_AXES];
   logic signed [AW-1:0]    op_u [NUM_AXES];
   logic signed [SUM_W-1:0] sum_p [NUM_AXES];
   logic signed [SUM_W-1:0] sum_v [NUM_AXES];
   logic signed [SUM_W-1:0] sum_z [NUM_AXES];

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         op_p[i] = AW'(pos_ff[i]);
         op_v[i] = AW'(vel_ff[i]);
         op_z[i] = AW'(piv_ff[i]);
         op_u[i] = AW'(a_vel_ff[i]);

         // p' = C*p + S*v + M*z + D*u
         sum_p[i] = SUM_W'(qmul(op_p[i], coef_cosh_ff))
                  + SUM_W'(qmul(op_v[i], coef_sinh_over_eta_ff))
                  + SUM_W'(qmul(op_z[i], coef_one_minus_cosh_ff))
                  + SUM_W'(qmul(op_u[i], coef_input_position_ff));
         // v' = E*p + C*v - E*z + M*u, E*z rounded on its own
         sum_v[i] = SUM_W'(qmul(op_p[i], coef_eta_sinh_ff))
                  + SUM_W'(qmul(op_v[i], coef_cosh_ff))
                  - SUM_W'(qmul(op_z[i], coef_eta_sinh_ff))
                  + SUM_W'(qmul(op_u[i], coef_one_minus_cosh_ff));
         // z' = z + T*u, unit weight on z applied exactly
         sum_z[i] = SUM_W'(piv_ff[i]) + SUM_W'(qmul(op_u[i], coef_step_s));

         if (a_action_ff == ACTION_RESTART) begin
            pos_in[i] = sat_value(WIDE_W'(a_start_ff[i]));
            piv_in[i] = sat_value(WIDE_W'(a_start_ff[i]));
            vel_in[i] = '0;
         end else begin
            pos_in[i] = sat_value(WIDE_W'(sum_p[i]));
            vel_in[i] = sat_value(WIDE_W'(sum_v[i]));
            piv_in[i] = sat_value(WIDE_W'(sum_z[i]));
         end

         // exact CoM minus ZMP, one bit wider
         diff_in[i] = (VALUE_BITS+1)'(pos_in[i]) - (VALUE_BITS+1)'(piv_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            piv_ff[i] <= '0;
         end
      end else if (a_fire) begin
         pos_ff <= pos_in;
         vel_ff <= vel_in;
         piv_ff <= piv_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage B: snapshot of the new state for this item
   // ---------------------------------------------------------------------------
   logic signed [VALUE_BITS-1:0] b_pos_ff  [NUM_AXES];
   logic signed [VALUE_BITS-1:0] b_vel_ff  [NUM_AXES];
   logic signed [VALUE_BITS-1:0] b_piv_ff  [NUM_AXES];
   logic signed [VALUE_BITS:0]   b_diff_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (a_fire) begin
         b_pos_ff  <= pos_in;
         b_vel_ff  <= vel_in;
         b_piv_ff  <= piv_in;
         b_diff_ff <= diff_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage C: acceleration multiply and result register
   // ---------------------------------------------------------------------------
   logic signed [FIELD_W-1:0] accel_in   [NUM_AXES];
   logic signed [FIELD_W-1:0] c_com_ff   [NUM_AXES];
   logic signed [FIELD_W-1:0] c_speed_ff [NUM_AXES];
   logic signed [FIELD_W-1:0] c_zmp_ff   [NUM_AXES];
   logic signed [FIELD_W-1:0] c_accel_ff [NUM_AXES];

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         accel_in[i] = sat_field(sat_value(WIDE_W'(qmul(AW'(b_diff_ff[i]),
                                                        coef_eta_sq_s))));
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready && b_valid_ff) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            c_com_ff[i]   <= sat_field(b_pos_ff[i]);
            c_speed_ff[i] <= sat_field(b_vel_ff[i]);
            c_zmp_ff[i]   <= sat_field(b_piv_ff[i]);
            c_accel_ff[i] <= accel_in[i];
         end
      end
   end

   assign rsp.com_x       = c_com_ff[0];
   assign rsp.com_y       = c_com_ff[1];
   assign rsp.com_speed_x = c_speed_ff[0];
   assign rsp.com_speed_y = c_speed_ff[1];
   assign rsp.zmp_x       = c_zmp_ff[0];
   assign rsp.zmp_y       = c_zmp_ff[1];
   assign rsp.com_accel_x = c_accel_ff[0];
   assign rsp.com_accel_y = c_accel_ff[1];

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------

   // restart zeroes both velocities
   a_restart_zero_vel: assert property (@(posedge clock) disable iff (reset)
      (a_fire && a_action_ff == ACTION_RESTART) |=>
         (vel_ff[0] == '0 && vel_ff[1] == '0))
      else $error("velocity not cleared by restart");

   // restart puts CoM on the ZMP, so the stage-B difference is zero
   a_restart_zero_diff: assert property (@(posedge clock) disable iff (reset)
      (a_fire && a_action_ff == ACTION_RESTART) |=>
         (b_diff_ff[0] == '0 && b_diff_ff[1] == '0))
      else $error("CoM-ZMP difference nonzero after restart");

   // state moves only when an item enters the update
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !a_fire |=> ($stable(pos_ff[0]) && $stable(pos_ff[1]) &&
                   $stable(piv_ff[0]) && $stable(piv_ff[1])))
      else $error("state changed without an item");

endmodule
